// File: design/sha1s_pkg.sv
// ----------------------------------------------------------------------------
// sha1s_pkg
// Shared types, constants and helpers for the SHA-1 stream hasher.
// ----------------------------------------------------------------------------
`default_nettype none

package sha1s_pkg;

  localparam logic [31:0] H0_INIT = 32'h67452301;
  localparam logic [31:0] H1_INIT = 32'hEFCDAB89;
  localparam logic [31:0] H2_INIT = 32'h98BADCFE;
  localparam logic [31:0] H3_INIT = 32'h10325476;
  localparam logic [31:0] H4_INIT = 32'hC3D2E1F0;

  localparam logic [31:0] K_0 = 32'h5A827999;
  localparam logic [31:0] K_1 = 32'h6ED9EBA1;
  localparam logic [31:0] K_2 = 32'h8F1BBCDC;
  localparam logic [31:0] K_3 = 32'hCA62C1D6;

  localparam logic [7:0]  PAD_BYTE   = 8'h80;
  localparam logic [6:0]  LAST_ROUND = 7'd79;
  localparam logic [5:0]  LAST_FILL  = 6'd63;
  localparam logic [5:0]  LEN_FILL   = 6'd56;
  localparam logic [2:0]  LAST_WIDX  = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FOLD,
    ST_PAD80,
    ST_PADZ,
    ST_PADLEN,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    BSEL_DATA,
    BSEL_PAD,
    BSEL_ZERO,
    BSEL_LEN
  } bsel_t;

  typedef struct packed {
    logic       shift_en;
    bsel_t      bsel;
    logic       count_inc;
    logic       count_clr;
    logic       init_work;
    logic       round_en;
    logic [6:0] round_idx;
    logic       fold;
    logic       chain_init;
    logic [2:0] word_idx;
  } dp_cmd_t;

  typedef struct packed {
    logic [5:0] fill;
  } dp_stat_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] d;
    d = {x, x} << n;
    return d[63:32];
  endfunction

endpackage

`default_nettype wire

// File: design/sha1s_if.sv
// ----------------------------------------------------------------------------
// sha1s_if
// Valid/ready channels for message bytes and digest words.
// ----------------------------------------------------------------------------
`default_nettype none

interface sha1s_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       end_of_message;
  modport source (output valid, output data_byte, output byte_present,
                  output end_of_message, input ready);
  modport sink   (input valid, input data_byte, input byte_present,
                  input end_of_message, output ready);
endinterface

interface sha1s_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic        last_word;
  modport source (output valid, output digest_word, output last_word, input ready);
  modport sink   (input valid, input digest_word, input last_word, output ready);
endinterface

`default_nettype wire

// File: design/sha1s_ctrl.sv
// ----------------------------------------------------------------------------
// sha1s_ctrl
// Sequencer: byte intake, padding, round count and digest readout.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1s_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_byte_present,
  input  wire logic              in_end,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire sha1s_pkg::dp_stat_t stat,
  output sha1s_pkg::dp_cmd_t     cmd
);
  import sha1s_pkg::*;

  state_t     state_r, state_nxt;
  state_t     ret_r, ret_nxt;
  logic [6:0] rnd_r, rnd_nxt;
  logic [2:0] widx_r, widx_nxt;
  logic       acc, full;

  assign acc  = in_valid && (state_r == ST_IDLE);
  assign full = (stat.fill == LAST_FILL);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ret_r   <= ST_IDLE;
      rnd_r   <= '0;
      widx_r  <= '0;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      rnd_r   <= rnd_nxt;
      widx_r  <= widx_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    rnd_nxt   = rnd_r;
    widx_nxt  = widx_r;
    case (state_r)
      ST_IDLE: begin
        if (acc) begin
          if (in_byte_present && full) begin
            state_nxt = ST_ROUND;
            ret_nxt   = in_end ? ST_PAD80 : ST_IDLE;
          end else if (in_end) begin
            state_nxt = ST_PAD80;
          end
        end
      end
      ST_ROUND: begin
        rnd_nxt = rnd_r + 7'd1;
        if (rnd_r == LAST_ROUND) begin
          rnd_nxt   = '0;
          state_nxt = ST_FOLD;
        end
      end
      ST_FOLD: state_nxt = ret_r;
      ST_PAD80: begin
        if (full) begin
          state_nxt = ST_ROUND;
          ret_nxt   = ST_PADZ;
        end else begin
          state_nxt = ST_PADZ;
        end
      end
      ST_PADZ: begin
        if (stat.fill == LEN_FILL) begin
          state_nxt = ST_PADLEN;
        end else if (full) begin
          state_nxt = ST_ROUND;
          ret_nxt   = ST_PADZ;
        end
      end
      ST_PADLEN: begin
        if (full) begin
          state_nxt = ST_ROUND;
          ret_nxt   = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_ready) begin
          widx_nxt = widx_r + 3'd1;
          if (widx_r == LAST_WIDX) begin
            widx_nxt  = '0;
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd           = '0;
    cmd.bsel      = BSEL_DATA;
    cmd.round_idx = rnd_r;
    cmd.word_idx  = widx_r;
    in_ready      = 1'b0;
    out_valid     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (acc && in_byte_present) begin
          cmd.shift_en  = 1'b1;
          cmd.count_inc = 1'b1;
          cmd.init_work = full;
        end
      end
      ST_ROUND: cmd.round_en = 1'b1;
      ST_FOLD:  cmd.fold = 1'b1;
      ST_PAD80: begin
        cmd.shift_en  = 1'b1;
        cmd.bsel      = BSEL_PAD;
        cmd.init_work = full;
      end
      ST_PADZ: begin
        if (stat.fill != LEN_FILL) begin
          cmd.shift_en  = 1'b1;
          cmd.bsel      = BSEL_ZERO;
          cmd.init_work = full;
        end
      end
      ST_PADLEN: begin
        cmd.shift_en  = 1'b1;
        cmd.bsel      = BSEL_LEN;
        cmd.init_work = full;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready && (widx_r == LAST_WIDX)) begin
          cmd.chain_init = 1'b1;
          cmd.count_clr  = 1'b1;
        end
      end
      default: cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

// File: design/sha1s_dp.sv
// ----------------------------------------------------------------------------
// sha1s_dp
// Block shift register, schedule, round unit, chaining value, byte count.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1s_dp (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire sha1s_pkg::dp_cmd_t cmd,
  input  wire logic [7:0]         in_data,
  output sha1s_pkg::dp_stat_t     stat,
  output logic [31:0]             digest_word,
  output logic                    last_word
);
  import sha1s_pkg::*;

  logic [511:0] blk_r;
  logic [31:0]  a_r, b_r, c_r, d_r, e_r;
  logic [31:0]  h_r [5];
  logic [60:0]  count_r;
  logic [5:0]   fill_r;
  logic [7:0]   byte_in;
  logic [63:0]  len_sh;
  logic [31:0]  w, w_new, f, k, t;

  // length byte selected by position within the last eight
  assign len_sh = {count_r, 3'b000} << {fill_r[2:0], 3'b000};

  always_comb begin
    case (cmd.bsel)
      BSEL_DATA: byte_in = in_data;
      BSEL_PAD:  byte_in = PAD_BYTE;
      BSEL_ZERO: byte_in = 8'h00;
      BSEL_LEN:  byte_in = len_sh[63:56];
      default:   byte_in = 8'h00;
    endcase
  end

  // oldest word at the top of the window
  assign w     = blk_r[511:480];
  assign w_new = rotl(blk_r[95:64] ^ blk_r[255:224] ^ blk_r[447:416] ^ blk_r[511:480],
                      5'd1);

  always_comb begin
    if (cmd.round_idx < 7'd20) begin
      f = d_r ^ (b_r & (c_r ^ d_r));
      k = K_0;
    end else if (cmd.round_idx < 7'd40) begin
      f = b_r ^ c_r ^ d_r;
      k = K_1;
    end else if (cmd.round_idx < 7'd60) begin
      f = (b_r & c_r) | (d_r & (b_r | c_r));
      k = K_2;
    end else begin
      f = b_r ^ c_r ^ d_r;
      k = K_3;
    end
  end

  assign t = rotl(a_r, 5'd5) + f + e_r + k + w;

  always_ff @(posedge clk) begin
    if (cmd.shift_en) begin
      blk_r <= {blk_r[503:0], byte_in};
    end else if (cmd.round_en) begin
      blk_r <= {blk_r[479:0], w_new};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init_work) begin
      a_r <= h_r[0];
      b_r <= h_r[1];
      c_r <= h_r[2];
      d_r <= h_r[3];
      e_r <= h_r[4];
    end else if (cmd.round_en) begin
      a_r <= t;
      b_r <= a_r;
      c_r <= rotl(b_r, 5'd30);
      d_r <= c_r;
      e_r <= d_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.chain_init) begin
      h_r[0] <= H0_INIT;
      h_r[1] <= H1_INIT;
      h_r[2] <= H2_INIT;
      h_r[3] <= H3_INIT;
      h_r[4] <= H4_INIT;
    end else if (cmd.fold) begin
      h_r[0] <= h_r[0] + a_r;
      h_r[1] <= h_r[1] + b_r;
      h_r[2] <= h_r[2] + c_r;
      h_r[3] <= h_r[3] + d_r;
      h_r[4] <= h_r[4] + e_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.count_clr) begin
      count_r <= '0;
      fill_r  <= '0;
    end else begin
      if (cmd.count_inc) count_r <= count_r + 61'd1;
      if (cmd.shift_en)  fill_r  <= fill_r + 6'd1;
    end
  end

  assign stat.fill   = fill_r;
  assign digest_word = h_r[cmd.word_idx];
  assign last_word   = (cmd.word_idx == LAST_WIDX);

endmodule

`default_nettype wire

// File: design/sha1_stream_hasher.sv
// ----------------------------------------------------------------------------
// sha1_stream_hasher
// SHA-1 over a byte stream, digest out as five 32-bit words.
// ----------------------------------------------------------------------------
// Takes at most one message byte per item and returns the SHA-1 digest as
// five words, H0 first, with last_word set on H4, after an item with
// end_of_message set. The 64th byte of a block starts the compression, which
// runs one round per cycle through a single round unit: 80 rounds, then one
// fold into the chaining value. Closing a message shifts the padding in one
// byte per cycle, pausing while it runs one or two more compressions, then
// holds each digest word until it is taken; the block is back to accepting
// bytes the cycle after H4 is taken, with chaining value and length reset for
// the next message.
`default_nettype none

module sha1_stream_hasher (
  input  wire logic  clk,
  input  wire logic  rst_n,
  sha1s_in_if.sink   in_ch,
  sha1s_out_if.source out_ch
);
  import sha1s_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer: drives handshakes, issues datapath commands
  sha1s_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_ch.valid),
    .in_byte_present (in_ch.byte_present),
    .in_end          (in_ch.end_of_message),
    .in_ready        (in_ch.ready),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .stat            (stat),
    .cmd             (cmd)
  );

  // datapath: hold block bytes, run rounds, keep chaining value
  sha1s_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .in_data     (in_ch.data_byte),
    .stat        (stat),
    .digest_word (out_ch.digest_word),
    .last_word   (out_ch.last_word)
  );

`ifndef NO_ASSERTIONS
  // never take an item while a digest word is pending
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && out_ch.valid))
    else $error("input ready while digest pending");

  // after the last word is taken, intake reopens
  a_back_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && out_ch.last_word) |=> in_ch.ready)
    else $error("not idle after digest");

  // rounds never run while bytes shift in
  a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.shift_en && cmd.round_en))
    else $error("shift and round together");
`endif

endmodule

`default_nettype wire
